// ===== sv/crc32ctc_pkg.sv =====
// Shared constants, types and the CRC-32C byte step for the trailer checker.
`default_nettype none

package crc32ctc_pkg;

  localparam int MARKER_FIELD_BYTES = 8;
  localparam int TRAILER_BYTES = 2 * MARKER_FIELD_BYTES + 4;
  localparam int MARKER_CMP_BYTES = (MARKER_FIELD_BYTES - 1 < 7) ? MARKER_FIELD_BYTES - 1 : 7;
  localparam int STORED_BASE = MARKER_FIELD_BYTES;
  localparam int MARKER2_BASE = MARKER_FIELD_BYTES + 4;
  localparam int CNT_W = $clog2(TRAILER_BYTES + 1);

  localparam logic [CNT_W-1:0] TRAILER_COUNT = CNT_W'(TRAILER_BYTES);

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_XOR_RESET = 32'hFFFF_FFFF;
  localparam logic [55:0] MARKER_RESET = 56'h6C_6D6D_2A68_7963;

  localparam int CFG_DATA_W = 56;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CHECK_MODE  = 2'd0,
    CFG_CRC_XOR     = 2'd1,
    CFG_MARKER_WORD = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_PASS       = 2'd0,
    ST_TOO_SHORT  = 2'd1,
    ST_MARKER_BAD = 2'd2,
    ST_CRC_BAD    = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] stored_crc;
    logic [31:0] computed_crc;
    status_t     status;
  } result_t;

  function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/crc32c_trailer_checker_top.sv =====
// Top level: input register, checker core and registered result output.
// A byte is taken into the input register and processed from there by the core;
// m_tvalid for a last byte is then set by the output register, later while held.
// Throughput: one byte per cycle, set by the single byte step of the CRC core.
// A stalled result holds only last bytes; other bytes keep flowing.
// Reset (rst, synchronous): control and config registers return to defaults, the buffer restarts.
`default_nettype none

module crc32c_trailer_checker_top
  import crc32ctc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // data_byte
  input  wire logic                   s_tlast,   // last_byte
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,   // status[1:0], computed_crc, stored_crc, zero pad
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       go;
  logic       out_free;
  result_t    result;
  result_t    out_result;

  assign out_free = !m_tvalid || m_tready;
  assign go = in_valid && (!in_last || out_free);
  assign s_tready = !in_valid || go;

  crc32ctc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .go        (go),
    .byte_in   (in_byte),
    .last_in   (in_last),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && in_last) begin
      out_result <= result;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - 66){1'b0}}, out_result.stored_crc,
                    out_result.computed_crc, out_result.status};

endmodule

`default_nettype wire

// ===== sv/crc32ctc_core.sv =====
// Configuration registers, running CRC, trailer delay line and result logic.
`default_nettype none

module crc32ctc_core
  import crc32ctc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   go,
  input  wire logic [7:0]             byte_in,
  input  wire logic                   last_in,
  output result_t                     result
);

  logic              check_mode;
  logic [31:0]       crc_xor;
  logic [55:0]       marker_word;
  logic [31:0]       crc_running;
  logic [31:0]       crc_next;
  logic [CNT_W-1:0]  bytes_seen;
  logic [CNT_W-1:0]  bytes_seen_next;
  logic [7:0]        window      [TRAILER_BYTES];
  logic [7:0]        window_next [TRAILER_BYTES];
  logic              full;
  logic              full_next;
  logic              marker_ok;
  logic [31:0]       stored;
  logic [31:0]       computed;

  always_comb begin
    for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
      window_next[i] = window[i+1];
    end
    window_next[TRAILER_BYTES-1] = byte_in;
  end

  assign full = (bytes_seen == TRAILER_COUNT);

  always_comb begin
    if (check_mode) begin
      crc_next = full ? crc_fold_byte(crc_running, window[0]) : crc_running;
      bytes_seen_next = full ? bytes_seen : bytes_seen + CNT_W'(1);
    end else begin
      crc_next = crc_fold_byte(crc_running, byte_in);
      bytes_seen_next = bytes_seen;
    end
  end

  assign full_next = (bytes_seen_next == TRAILER_COUNT);
  assign computed = crc_next ^ crc_xor;
  assign stored = {window_next[STORED_BASE+3], window_next[STORED_BASE+2],
                   window_next[STORED_BASE+1], window_next[STORED_BASE]};

  always_comb begin
    marker_ok = 1'b1;
    for (int i = 0; i < MARKER_CMP_BYTES; i++) begin
      if (window_next[i] != marker_word[8*i +: 8]) marker_ok = 1'b0;
      if (window_next[MARKER2_BASE+i] != marker_word[8*i +: 8]) marker_ok = 1'b0;
    end
  end

  always_comb begin
    result.status = ST_PASS;
    result.computed_crc = computed;
    result.stored_crc = 32'd0;
    if (check_mode) begin
      if (!full_next) begin
        result.status = ST_TOO_SHORT;
        result.computed_crc = 32'd0;
      end else begin
        result.stored_crc = stored;
        if (!marker_ok) begin
          result.status = ST_MARKER_BAD;
        end else if (stored != computed) begin
          result.status = ST_CRC_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= 1'b1;
      crc_xor <= CRC_XOR_RESET;
      marker_word <= MARKER_RESET;
      crc_running <= CRC_XOR_RESET;
      bytes_seen <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_CHECK_MODE:  check_mode <= cfg_data[0];
        CFG_CRC_XOR:     crc_xor <= cfg_data[31:0];
        CFG_MARKER_WORD: marker_word <= cfg_data[55:0];
        default: ;
      endcase
      crc_running <= (cfg_index_t'(cfg_index) == CFG_CRC_XOR) ? cfg_data[31:0] : crc_xor;
      bytes_seen <= '0;
    end else if (go) begin
      if (last_in) begin
        crc_running <= crc_xor;
        bytes_seen <= '0;
      end else begin
        crc_running <= crc_next;
        bytes_seen <= bytes_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_crc32c_trailer_checker_top.sv =====
// Self-checking testbench for the CRC-32C trailer checker: stream stimulus, predictor, scoreboard.
`default_nettype none

module tb_crc32c_trailer_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crc32ctc_pkg::*;

  localparam int ITEMS = 1300;
  localparam int PHASES = 8;
  localparam int HOLD_CYCLES = 300;

  typedef enum {
    BUF_GOOD,
    BUF_BAD_MARKER,
    BUF_BAD_CRC,
    BUF_SHORT,
    BUF_NOISE
  } buffer_kind_t;

  class crc_trailer_scoreboard;
    bit          check_mode;
    logic [31:0] crc_xor;
    logic [55:0] marker_word;
    logic [31:0] crc_run;
    logic [7:0]  window [TRAILER_BYTES];
    int          seen;
    result_t     expected_q[$];
    int          errors;
    int          requests;
    int          results_checked;
    int          reg_writes;
    int          status_count [4];

    function new();
      check_mode = 1'b1;
      crc_xor = CRC_XOR_RESET;
      marker_word = MARKER_RESET;
      errors = 0;
      requests = 0;
      results_checked = 0;
      reg_writes = 0;
      foreach (status_count[i]) status_count[i] = 0;
      restart();
    endfunction

    function void restart();
      crc_run = crc_xor;
      seen = 0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] c;
      int k;
      c = crc ^ {24'd0, b};
      for (k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function bit marker_matches(int base);
      int i;
      for (i = 0; i < MARKER_CMP_BYTES; i++) begin
        if (window[base + i] != marker_word[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHECK_MODE:  check_mode = data[0];
        CFG_CRC_XOR:     crc_xor = data[31:0];
        CFG_MARKER_WORD: marker_word = data[55:0];
        default: ;
      endcase
      reg_writes++;
      restart();
    endfunction

    function void note_request(logic [7:0] b, logic last);
      result_t r;
      int i;
      requests++;
      if (check_mode) begin
        if (seen >= TRAILER_BYTES) begin
          crc_run = crc_step(crc_run, window[0]);
          for (i = 0; i < TRAILER_BYTES - 1; i++) window[i] = window[i + 1];
          window[TRAILER_BYTES - 1] = b;
        end else begin
          window[seen] = b;
          seen++;
        end
      end else begin
        crc_run = crc_step(crc_run, b);
      end
      if (!last) return;
      r.status = ST_PASS;
      r.computed_crc = '0;
      r.stored_crc = '0;
      if (!check_mode) begin
        r.computed_crc = crc_run ^ crc_xor;
      end else if (seen < TRAILER_BYTES) begin
        r.status = ST_TOO_SHORT;
      end else begin
        r.computed_crc = crc_run ^ crc_xor;
        for (i = 3; i >= 0; i--) r.stored_crc = {r.stored_crc[23:0], window[STORED_BASE + i]};
        if (!marker_matches(0) || !marker_matches(MARKER2_BASE)) r.status = ST_MARKER_BAD;
        else if (r.stored_crc != r.computed_crc) r.status = ST_CRC_BAD;
      end
      expected_q.push_back(r);
      status_count[int'(r.status)]++;
      restart();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("ERROR at %0t: %s got %h want %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data);
      result_t got;
      result_t want;
      got = data[$bits(result_t)-1:0];
      results_checked++;
      if (expected_q.size() == 0) begin
        report("unexpected result, computed_crc", got.computed_crc, '0);
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status) report("status", 32'(got.status), 32'(want.status));
        if (got.computed_crc != want.computed_crc)
          report("computed_crc", got.computed_crc, want.computed_crc);
        if (got.stored_crc != want.stored_crc)
          report("stored_crc", got.stored_crc, want.stored_crc);
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  wire logic              s_tready;
  logic [7:0]             s_tdata;
  logic                   s_tlast;
  wire logic              m_tvalid;
  logic                   m_tready;
  wire logic [OUT_DATA_W-1:0] m_tdata;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bit idle_on = 1'b0;
  bit receiver_hold = 1'b0;
  logic [7:0] frame_q[$];

  crc_trailer_scoreboard sb = new();

  crc32c_trailer_checker_top DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("crc32c_trailer_checker_top: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) sb.note_request(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (receiver_hold) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        receiver_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(0, 16)) @(negedge clk);
      end
    end
  end

  task automatic idle_gap(int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    if (idle_on && $urandom_range(0, 5) == 0) idle_gap($urandom_range(1, 17));
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_buffer(bit end_with_last);
    int i;
    for (i = 0; i < frame_q.size(); i++) begin
      send_byte(frame_q[i], end_with_last && (i == frame_q.size() - 1));
    end
  endtask

  task automatic wait_results_done();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    wait_results_done();
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [55:0] rand_marker();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[55:0];
  endfunction

  function automatic buffer_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (!sb.check_mode) return BUF_NOISE;
    if (r < 50) return BUF_GOOD;
    if (r < 62) return BUF_BAD_MARKER;
    if (r < 74) return BUF_BAD_CRC;
    if (r < 86) return BUF_SHORT;
    return BUF_NOISE;
  endfunction

  task automatic build_frame(buffer_kind_t kind);
    int plen;
    int pos;
    int k;
    logic [7:0] b;
    logic [31:0] crc;
    frame_q.delete();
    case (kind)
      BUF_SHORT: repeat ($urandom_range(1, TRAILER_BYTES - 1)) frame_q.push_back(8'($urandom));
      BUF_NOISE: repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
      default: begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        crc = sb.crc_xor;
        repeat (plen) begin
          b = 8'($urandom);
          frame_q.push_back(b);
          crc = sb.crc_step(crc, b);
        end
        crc = crc ^ sb.crc_xor;
        if (kind == BUF_BAD_CRC) crc = crc ^ (32'd1 << $urandom_range(0, 31));
        repeat (TRAILER_BYTES) frame_q.push_back(8'($urandom));
        for (k = 0; k < MARKER_CMP_BYTES; k++) begin
          frame_q[plen + k] = sb.marker_word[8*k +: 8];
          frame_q[plen + MARKER2_BASE + k] = sb.marker_word[8*k +: 8];
        end
        for (k = 0; k < 4; k++) frame_q[plen + STORED_BASE + k] = crc[8*k +: 8];
        if (kind == BUF_BAD_MARKER) begin
          pos = plen + ($urandom_range(0, 1) ? MARKER2_BASE : 0)
              + $urandom_range(0, MARKER_CMP_BYTES - 1);
          frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
        end
      end
    endcase
  endtask

  initial begin
    int k;
    int phase;
    result_t r;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_byte(8'hFF, 1'b1);
    frame_q.delete();
    repeat (TRAILER_BYTES) frame_q.push_back(8'h00);
    for (k = 0; k < MARKER_CMP_BYTES; k++) begin
      frame_q[k] = sb.marker_word[8*k +: 8];
      frame_q[MARKER2_BASE + k] = sb.marker_word[8*k +: 8];
    end
    frame_q[TRAILER_BYTES - 1] = 8'hFF;
    send_buffer(1'b1);

    idle_on = 1'b1;
    receiver_hold = 1'b1;
    repeat (40) send_byte(8'($urandom), 1'b1);
    wait_results_done();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        1: write_reg(CFG_CRC_XOR, '0);
        2: begin
          write_reg(CFG_MARKER_WORD, {CFG_DATA_W{1'b1}});
          write_reg(CFG_CRC_XOR, CFG_DATA_W'($urandom));
        end
        3: begin
          write_reg(CFG_CHECK_MODE, '0);
          write_reg(CFG_CRC_XOR, CFG_DATA_W'(32'hFFFF_FFFF));
        end
        4: begin
          write_reg(CFG_CHECK_MODE, CFG_DATA_W'(1));
          write_reg(CFG_MARKER_WORD, '0);
          write_reg(CFG_UNUSED, rand_marker());
        end
        5: begin
          write_reg(CFG_MARKER_WORD, rand_marker());
          write_reg(CFG_CRC_XOR, CFG_DATA_W'($urandom));
        end
        6: begin
          write_reg(CFG_CHECK_MODE, '0);
          write_reg(CFG_CRC_XOR, '0);
        end
        7: begin
          write_reg(CFG_CHECK_MODE, CFG_DATA_W'(1));
          write_reg(CFG_CRC_XOR, CFG_DATA_W'(32'hFFFF_FFFF));
          write_reg(CFG_MARKER_WORD, MARKER_RESET);
        end
        default: ;
      endcase
      idle_on = (phase != PHASES - 1);
      while (sb.requests < (phase + 1) * ITEMS / PHASES) begin
        build_frame(pick_kind());
        send_buffer(1'b1);
      end
      if (phase == 1 || phase == 4) begin
        build_frame(BUF_NOISE);
        send_buffer(1'b0);
      end
    end

    wait_results_done();
    repeat (10) @(posedge clk);
    while (sb.expected_q.size() != 0) begin
      r = sb.expected_q.pop_front();
      sb.report("missing result, computed_crc", '0, r.computed_crc);
    end
    $display("run: %0d bytes, %0d results checked, %0d register writes",
             sb.requests, sb.results_checked, sb.reg_writes);
    $display("status mix: %0d pass, %0d too short, %0d marker bad, %0d crc bad",
             sb.status_count[int'(ST_PASS)], sb.status_count[int'(ST_TOO_SHORT)],
             sb.status_count[int'(ST_MARKER_BAD)], sb.status_count[int'(ST_CRC_BAD)]);
    if (sb.errors == 0) begin
      $display("crc32c_trailer_checker_top: match");
    end else begin
      $display("crc32c_trailer_checker_top: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
